// ----- hw/rtl/srsw_pkg.sv -----
// shared types, constants and the modulo reducer of the send window
package srsw_pkg;

  // default configuration
  localparam int unsigned SRSW_WINDOW_SIZE = 8;
  localparam int unsigned SRSW_SEQ_SPACE   = 256;

  // fixed port widths
  localparam int unsigned SEQ_PORT_W  = 8;
  localparam int unsigned SLOT_PORT_W = 4;
  localparam int unsigned MODE_W      = 2;
  // width of the reducer operand (sequence number plus window count)
  localparam int unsigned ACC_W       = 9;
  // shift and width of the reducer reciprocal
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 16;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_ACK    = 2'd1,
    MODE_LOCATE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EXEC,
    ST_SLIDE,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic exec;
    logic step;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slide_req;
    logic slide_more;
  } dp_status_t;

  // x modulo m by reciprocal multiplication, recip = floor(2^RECIP_SHIFT / m)
  // the quotient estimate is at most one low, one compare and subtract fixes it
  function automatic logic [ACC_W-1:0] mod_reduce(input logic [ACC_W-1:0]   x,
                                                  input logic [ACC_W-1:0]   m,
                                                  input logic [RECIP_W-1:0] recip);
    logic [ACC_W+RECIP_W-1:0] prod;
    logic [ACC_W-1:0]         quo;
    logic [2*ACC_W-1:0]       back;
    logic [ACC_W-1:0]         rem;
    prod = (ACC_W+RECIP_W)'(x) * (ACC_W+RECIP_W)'(recip);
    quo  = ACC_W'(prod >> RECIP_SHIFT);
    back = (2*ACC_W)'(quo) * (2*ACC_W)'(m);
    rem  = x - back[ACC_W-1:0];
    if (rem >= m) begin
      rem = rem - m;
    end
    return rem;
  endfunction

endpackage

// ----- hw/rtl/selective_repeat_send_window.sv -----
// top level of the selective-repeat send window
// a request passes the states PREP, EXEC and DONE; an ack that moves the base
// also passes SLIDE before DONE, walking further acked slots one slot a cycle
// no new request is taken until the result strobe of the last one
// reset: flags, base and top slots and base sequence clear at once, no sweep
// results carry no backpressure and are taken in the strobe cycle
module selective_repeat_send_window
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = SRSW_WINDOW_SIZE,
  parameter int unsigned SEQ_SPACE   = SRSW_SEQ_SPACE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [SEQ_PORT_W-1:0]  seq_number_i,
  output logic                   done_o,
  output logic                   ok_o,
  output logic [SEQ_PORT_W-1:0]  seq_out_o,
  output logic [SLOT_PORT_W-1:0] slot_o,
  output logic                   slid_o,
  output logic [SEQ_PORT_W-1:0]  base_seq_out_o,
  output logic [SLOT_PORT_W-1:0] in_flight_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  srsw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  // datapath
  srsw_dpath #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SEQ_SPACE   (SEQ_SPACE)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_i),
    .seq_number_i   (seq_number_i),
    .ok_o           (ok_o),
    .seq_out_o      (seq_out_o),
    .slot_o         (slot_o),
    .slid_o         (slid_o),
    .base_seq_out_o (base_seq_out_o),
    .in_flight_o    (in_flight_o)
  );

  // an accepted transfer keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a request");

  // the block frees up right after the result strobe
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("block still busy after result strobe");

  // a base slide only comes with a valid ack
  a_slid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && slid_o |-> ok_o)
    else $error("base slid on an invalid request");

  // slide walk only follows an acked base
  a_step_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> busy && !done_o)
    else $error("slide step outside a request");

endmodule

// ----- hw/rtl/srsw_ctrl.sv -----
// controller state machine of the send window
module srsw_ctrl
  import srsw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output logic       busy,
  output logic       done_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_PREP;
      ST_PREP:  state_d = ST_EXEC;
      ST_EXEC:  state_d = status_i.slide_req ? ST_SLIDE : ST_DONE;
      ST_SLIDE: if (!status_i.slide_more) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_PREP:  cmd_o.prep = 1'b1;
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_SLIDE: cmd_o.step = status_i.slide_more;
      ST_DONE:  done_o = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

// ----- hw/rtl/srsw_dpath.sv -----
// datapath of the send window: flag ring, pointers, base sequence, result
module srsw_dpath
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = SRSW_WINDOW_SIZE,
  parameter int unsigned SEQ_SPACE   = SRSW_SEQ_SPACE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [SEQ_PORT_W-1:0]  seq_number_i,
  output logic                   ok_o,
  output logic [SEQ_PORT_W-1:0]  seq_out_o,
  output logic [SLOT_PORT_W-1:0] slot_o,
  output logic                   slid_o,
  output logic [SEQ_PORT_W-1:0]  base_seq_out_o,
  output logic [SLOT_PORT_W-1:0] in_flight_o
);

  localparam int unsigned RING      = WINDOW_SIZE + 1;
  localparam int unsigned SLOT_W    = $clog2(RING);
  localparam int unsigned SEQ_W     = $clog2(SEQ_SPACE);
  localparam int unsigned SEQ_RECIP = (1 << RECIP_SHIFT) / SEQ_SPACE;

  // request and state registers
  mode_e                   mode_q;
  logic [SEQ_PORT_W-1:0]   seq_in_q;
  logic [SEQ_W-1:0]        seq_red_q;
  logic [RING-1:0]         flags_q;
  logic [SLOT_W-1:0]       base_q;
  logic [SLOT_W-1:0]       top_q;
  logic [SEQ_W-1:0]        base_seq_q;
  logic                    ok_q;
  logic [SEQ_PORT_W-1:0]   seq_out_q;
  logic [SLOT_PORT_W-1:0]  slot_q;
  logic                    slid_q;

  logic [SLOT_W:0]         cnt_sum;
  logic [SLOT_W-1:0]       count;
  logic [ACC_W-1:0]        red_in;
  logic [ACC_W-1:0]        red_out;
  logic [SEQ_W:0]          off_diff;
  logic [SEQ_W:0]          off_wrap;
  logic [SEQ_W-1:0]        offset;
  logic                    in_range;
  logic [SLOT_W:0]         idx_sum;
  logic [SLOT_W-1:0]       idx;
  logic [SLOT_W-1:0]       base_inc;
  logic [SLOT_W-1:0]       top_inc;
  logic [SEQ_W-1:0]        base_seq_inc;

  // outstanding count, ring distance from base to top
  always_comb begin
    cnt_sum = (SLOT_W+1)'(top_q) + (SLOT_W+1)'(RING) - (SLOT_W+1)'(base_q);
    if (cnt_sum >= (SLOT_W+1)'(RING)) begin
      cnt_sum = cnt_sum - (SLOT_W+1)'(RING);
    end
    count = cnt_sum[SLOT_W-1:0];
  end

  // shared modulo reducer: raw sequence number, then allocated number
  assign red_in  = cmd_i.prep ? ACC_W'(seq_in_q)
                              : ACC_W'(base_seq_q) + ACC_W'(count);
  assign red_out = mod_reduce(red_in, ACC_W'(SEQ_SPACE), RECIP_W'(SEQ_RECIP));

  // offset of the request from the base sequence number
  always_comb begin
    off_diff = {1'b0, seq_red_q} - {1'b0, base_seq_q};
    off_wrap = off_diff + (SEQ_W+1)'(SEQ_SPACE);
    offset   = off_diff[SEQ_W] ? off_wrap[SEQ_W-1:0] : off_diff[SEQ_W-1:0];
    in_range = ACC_W'(offset) < ACC_W'(count);
  end

  // ring slot of the request
  always_comb begin
    idx_sum = (SLOT_W+1)'(base_q) + (SLOT_W+1)'(offset);
    if (idx_sum >= (SLOT_W+1)'(RING)) begin
      idx_sum = idx_sum - (SLOT_W+1)'(RING);
    end
    idx = idx_sum[SLOT_W-1:0];
  end

  // pointer increments
  assign base_inc     = (base_q == SLOT_W'(RING - 1)) ? '0 : base_q + 1'b1;
  assign top_inc      = (top_q == SLOT_W'(RING - 1)) ? '0 : top_q + 1'b1;
  assign base_seq_inc = (base_seq_q == SEQ_W'(SEQ_SPACE - 1)) ? '0 : base_seq_q + 1'b1;

  // status to controller
  assign status_o.slide_req  = cmd_i.exec && (mode_q == MODE_ACK) && in_range &&
                               (idx == base_q);
  assign status_o.slide_more = (base_q != top_q) && !flags_q[base_q];

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_e'(mode_i);
      seq_in_q <= seq_number_i;
    end
    if (cmd_i.prep) begin
      seq_red_q <= red_out[SEQ_W-1:0];
    end
  end

  // window state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      base_q     <= '0;
      top_q      <= '0;
      base_seq_q <= '0;
      ok_q       <= 1'b0;
      seq_out_q  <= '0;
      slot_q     <= '0;
      slid_q     <= 1'b0;
    end else if (cmd_i.exec) begin
      ok_q      <= 1'b0;
      seq_out_q <= '0;
      slot_q    <= '0;
      slid_q    <= 1'b0;
      unique case (mode_q)
        MODE_ALLOC: begin
          if (ACC_W'(count) < ACC_W'(WINDOW_SIZE)) begin
            ok_q           <= 1'b1;
            seq_out_q      <= SEQ_PORT_W'(red_out[SEQ_W-1:0]);
            slot_q         <= SLOT_PORT_W'(top_q);
            flags_q[top_q] <= 1'b1;
            top_q          <= top_inc;
          end
        end
        MODE_ACK: begin
          if (in_range) begin
            ok_q         <= 1'b1;
            seq_out_q    <= SEQ_PORT_W'(seq_red_q);
            slot_q       <= SLOT_PORT_W'(idx);
            flags_q[idx] <= 1'b0;
            // acked base: first slide step, the rest walks slot by slot
            if (idx == base_q) begin
              base_q     <= base_inc;
              base_seq_q <= base_seq_inc;
              slid_q     <= 1'b1;
            end
          end
        end
        MODE_LOCATE: begin
          if (in_range && flags_q[idx]) begin
            ok_q      <= 1'b1;
            seq_out_q <= SEQ_PORT_W'(seq_red_q);
            slot_q    <= SLOT_PORT_W'(idx);
          end
        end
        MODE_NONE: begin
          ok_q <= 1'b0;
        end
        default: begin
          ok_q <= 1'b0;
        end
      endcase
    end else if (cmd_i.step && status_o.slide_more) begin
      // slide base past one acknowledged slot
      base_q     <= base_inc;
      base_seq_q <= base_seq_inc;
    end
  end

  // result ports
  assign ok_o           = ok_q;
  assign seq_out_o      = seq_out_q;
  assign slot_o         = slot_q;
  assign slid_o         = slid_q;
  assign base_seq_out_o = SEQ_PORT_W'(base_seq_q);
  assign in_flight_o    = SLOT_PORT_W'(count);

endmodule

// ----- sim/tb.sv -----
// testbench for the selective-repeat send window: directed and random requests
`timescale 1ns / 100ps

module tb;
  import srsw_pkg::*;

  localparam int unsigned WINDOW   = SRSW_WINDOW_SIZE;
  localparam int unsigned RING     = WINDOW + 1;
  localparam int unsigned SEQ_MOD  = SRSW_SEQ_SPACE;
  localparam int unsigned N_RANDOM = 475;

  // one result of the window
  typedef struct {
    logic                   ok;
    logic [SEQ_PORT_W-1:0]  seq_out;
    logic [SLOT_PORT_W-1:0] slot;
    logic                   slid;
    logic [SEQ_PORT_W-1:0]  base_seq;
    logic [SLOT_PORT_W-1:0] in_flight;
  } window_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [MODE_W-1:0]      mode_i = MODE_NONE;
  logic [SEQ_PORT_W-1:0]  seq_number_i = '0;
  logic                   done_o;
  logic                   ok_o;
  logic [SEQ_PORT_W-1:0]  seq_out_o;
  logic [SLOT_PORT_W-1:0] slot_o;
  logic                   slid_o;
  logic [SEQ_PORT_W-1:0]  base_seq_out_o;
  logic [SLOT_PORT_W-1:0] in_flight_o;

  // window state as predicted from the accepted requests
  logic [RING-1:0]        win_flags = '0;
  logic [SLOT_PORT_W-1:0] win_base_slot = '0;
  logic [SLOT_PORT_W-1:0] win_top_slot = '0;
  logic [SEQ_PORT_W-1:0]  win_base_seq = '0;

  window_result_t awaited_results[$];
  int unsigned    fail_count = 0;
  int unsigned    requests_sent = 0;
  int unsigned    results_seen = 0;
  int unsigned    slides_seen = 0;
  int unsigned    rejects_seen = 0;
  bit             gaps_enabled = 1'b0;

  selective_repeat_send_window DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .seq_number_i   (seq_number_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .seq_out_o      (seq_out_o),
    .slot_o         (slot_o),
    .slid_o         (slid_o),
    .base_seq_out_o (base_seq_out_o),
    .in_flight_o    (in_flight_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("selective_repeat_send_window verification failed");
    $finish;
  end

  function automatic int unsigned ring_span(input int unsigned hi, input int unsigned lo);
    return (hi + RING - lo) % RING;
  endfunction

  function automatic int unsigned window_count();
    return ring_span(32'(win_top_slot), 32'(win_base_slot));
  endfunction

  // advance the predicted window by one request and queue its result
  task automatic apply_window_request(input mode_e req, input logic [SEQ_PORT_W-1:0] seq);
    window_result_t r;
    int unsigned    count;
    int unsigned    offset;
    int unsigned    idx;
    int unsigned    walk;
    count  = window_count();
    offset = (seq % SEQ_MOD + SEQ_MOD - win_base_seq) % SEQ_MOD;
    r = '{default: '0};
    case (req)
      MODE_ALLOC: begin
        if (count < WINDOW) begin
          r.ok      = 1'b1;
          r.seq_out = SEQ_PORT_W'((win_base_seq + count) % SEQ_MOD);
          r.slot    = win_top_slot;
          win_flags[win_top_slot] = 1'b1;
          win_top_slot = SLOT_PORT_W'((win_top_slot + 1) % RING);
        end
      end
      MODE_ACK: begin
        if (offset < count) begin
          idx       = (win_base_slot + offset) % RING;
          r.ok      = 1'b1;
          r.seq_out = SEQ_PORT_W'(seq % SEQ_MOD);
          r.slot    = SLOT_PORT_W'(idx);
          win_flags[idx] = 1'b0;
          // base slides over every cleared slot, stopping at top
          if (idx == win_base_slot) begin
            walk = (idx + 1) % RING;
            while (walk != win_top_slot && !win_flags[walk]) walk = (walk + 1) % RING;
            win_base_seq  = SEQ_PORT_W'((win_base_seq + ring_span(walk, 32'(win_base_slot)))
                                        % SEQ_MOD);
            win_base_slot = SLOT_PORT_W'(walk);
            r.slid        = 1'b1;
          end
        end
      end
      MODE_LOCATE: begin
        if (offset < count) begin
          idx = (win_base_slot + offset) % RING;
          if (win_flags[idx]) begin
            r.ok      = 1'b1;
            r.seq_out = SEQ_PORT_W'(seq % SEQ_MOD);
            r.slot    = SLOT_PORT_W'(idx);
          end
        end
      end
      default: ;
    endcase
    r.base_seq  = win_base_seq;
    r.in_flight = SLOT_PORT_W'(window_count());
    awaited_results.push_back(r);
  endtask

  // one request transfer; start stays high afterwards for back-to-back requests
  task automatic send_request(input mode_e req, input logic [SEQ_PORT_W-1:0] seq,
                              input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= req;
    seq_number_i <= seq;
    do @(posedge clk_i); while (busy);
    apply_window_request(req, seq);
    requests_sent++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold the sender off until every result is back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [SEQ_PORT_W-1:0] expv,
                             input logic [SEQ_PORT_W-1:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    window_result_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (slid_o) slides_seen++;
      if (!ok_o) rejects_seen++;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = awaited_results.pop_front();
        check_field("ok", SEQ_PORT_W'(e.ok), SEQ_PORT_W'(ok_o));
        check_field("seq_out", e.seq_out, seq_out_o);
        check_field("slot", SEQ_PORT_W'(e.slot), SEQ_PORT_W'(slot_o));
        check_field("slid", SEQ_PORT_W'(e.slid), SEQ_PORT_W'(slid_o));
        check_field("base_seq_out", e.base_seq, base_seq_out_o);
        check_field("in_flight", SEQ_PORT_W'(e.in_flight), SEQ_PORT_W'(in_flight_o));
      end
    end
  end

  // requests against an empty window are all rejected
  task automatic test_empty_window();
    send_request(MODE_LOCATE, 8'd0, 0);
    send_request(MODE_ACK, 8'd0, 0);
    send_request(MODE_ACK, 8'd255, 1);
    send_request(MODE_NONE, 8'd170, 0);
    drain_results();
  endtask

  // fill all slots, one more allocate hits the full window, then locate the last one
  task automatic test_fill_window();
    for (int i = 0; i < WINDOW; i++) send_request(MODE_ALLOC, 8'($urandom_range(0, 255)), 0);
    send_request(MODE_ALLOC, 8'd0, 0);
    send_request(MODE_LOCATE, 8'(WINDOW - 1), 2);
    drain_results();
  endtask

  // holes, duplicate ack, a stale locate, out of range ack and long base walks
  task automatic test_out_of_order_acks();
    send_request(MODE_ACK, 8'd3, 0);
    send_request(MODE_ACK, 8'd3, 0);
    send_request(MODE_LOCATE, 8'd3, 0);
    send_request(MODE_ACK, 8'd1, 1);
    send_request(MODE_ACK, 8'd2, 0);
    send_request(MODE_ACK, 8'd0, 0);
    send_request(MODE_ACK, 8'd200, 0);
    send_request(MODE_ACK, 8'd7, 0);
    send_request(MODE_ACK, 8'd5, 3);
    send_request(MODE_ACK, 8'd6, 0);
    send_request(MODE_ACK, 8'd4, 0);
    drain_results();
  endtask

  // random traffic, mostly acks and locates of sequence numbers in flight
  task automatic test_random_traffic();
    int unsigned   r;
    int unsigned   count;
    mode_e         req;
    logic [SEQ_PORT_W-1:0] seq;
    for (int i = 0; i < N_RANDOM; i++) begin
      gaps_enabled = !(i >= 150 && i < 250);
      if (i == 320) drain_results();
      count = window_count();
      r = $urandom_range(0, 99);
      seq = 8'($urandom_range(0, 255));
      if (r < 42) req = MODE_ALLOC;
      else if (r < 75) req = MODE_ACK;
      else if (r < 92) req = MODE_LOCATE;
      else if (r < 96) req = MODE_NONE;
      else req = ($urandom_range(0, 1) != 0) ? MODE_ACK : MODE_LOCATE;
      // in-range sequence numbers for all but the noise share
      if ((req == MODE_ACK || req == MODE_LOCATE) && r < 92 && count > 0)
        seq = 8'((win_base_seq + $urandom_range(0, count - 1)) % SEQ_MOD);
      send_request(req, seq, pick_gap());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_window();
    test_fill_window();
    test_out_of_order_acks();
    test_random_traffic();
    drain_results();
    repeat (WINDOW + 8) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked", requests_sent, results_seen);
    $display("base slides %0d, rejected requests %0d", slides_seen, rejects_seen);
    if (fail_count == 0) begin
      $display("selective_repeat_send_window verification clean");
    end else begin
      $display("selective_repeat_send_window verification failed");
    end
    $finish;
  end

endmodule
